>>> rtl/lwfs_pkg.sv
package lwfs_pkg;

  // Default coordinate width; the panel protocol always sends 16-bit values
  localparam int unsigned CoordBitsDefault = 16;

  // Widths of the stream fields
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 2 * SizeW;

  // Panel command bytes
  localparam logic [ByteW-1:0] CmdColAddrSet = 8'h2A;
  localparam logic [ByteW-1:0] CmdRowAddrSet = 8'h2B;
  localparam logic [ByteW-1:0] CmdMemWrite   = 8'h2C;

  // Request codes
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqStart = 1'b1;

  // Pack an RGB888 colour into RGB565
  function automatic logic [WordW-1:0] rgb565(input logic [7:0] r,
                                              input logic [7:0] g,
                                              input logic [7:0] b);
    logic [7:0] r_m;
    logic [7:0] g_m;
    r_m = r & 8'hF8;
    g_m = g & 8'hFC;
    return {r_m[7:3], g_m[7:2], b[7:3]};
  endfunction

endpackage

>>> rtl/lwfs_req_if.sv
interface lwfs_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, req_type, rect_x, rect_y, rect_width, rect_height,
                  red, green, blue, input ready);
  modport sink   (input valid, req_type, rect_x, rect_y, rect_width, rect_height,
                  red, green, blue, output ready);
endinterface

>>> rtl/lwfs_strm_if.sv
interface lwfs_strm_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_of_rect;

  modport source (output valid, out_byte, is_data, last_of_rect, input ready);
  modport sink   (input valid, out_byte, is_data, last_of_rect, output ready);
endinterface

>>> rtl/lcd_window_fill_sequencer.sv
// LCD window fill sequencer.
// Request channel (req_i): a start transaction latches a rectangle and an
// RGB888 colour and gives no output; each tick transaction then yields the
// next byte of the panel stream on strm_o: column address set with x start
// and end, row address set with y start and end, memory write, then
// width*height RGB565 pixels, high byte first. last_of_rect marks the final
// byte. A tick while idle gives nothing; a start mid-stream restarts.
// The byte for a tick is valid on strm_o the cycle after the tick is taken.
// Throughput: one transaction per cycle unless the receiver stalls, set
// by the single sequencer state register feeding one output register; the
// pixel count is one 16x16 multiply done as the start is taken.
// Reset puts the sequencer idle and empties the output register.
// When the receiver stalls with a byte held, req_i.ready drops until the
// byte is taken; no byte is lost or repeated.
module lcd_window_fill_sequencer
  import lwfs_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lwfs_req_if.sink    req_i,
  lwfs_strm_if.source strm_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhCaset,
    PhXParam,
    PhRaset,
    PhYParam,
    PhRamwr,
    PhPixels
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [1:0]          pidx_q, pidx_d;
  logic                low_q, low_d;
  logic [CountW-1:0]   left_q, left_d;
  logic [COORD_BITS-1:0] xs_q, xe_q, ys_q, ye_q;
  logic [WordW-1:0]    color_q;

  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    byte_q, byte_d;
  logic                data_q, data_d;
  logic                last_q, last_d;

  logic                accept;
  logic                start;
  logic                emit;
  logic [WordW-1:0]    bound;
  logic [WordW-1:0]    x_end_w;
  logic [WordW-1:0]    y_end_w;

  assign req_i.ready = !out_valid_q || strm_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign start       = accept && (req_i.req_type == ReqStart);

  // End coordinates wrap at the coordinate width
  assign x_end_w = req_i.rect_x + req_i.rect_width - WordW'(1);
  assign y_end_w = req_i.rect_y + req_i.rect_height - WordW'(1);

  // Select the parameter word: bit 1 picks end over start
  always_comb begin
    unique case ({phase_q == PhYParam, pidx_q[1]})
      2'b00:   bound = WordW'(xs_q);
      2'b01:   bound = WordW'(xe_q);
      2'b10:   bound = WordW'(ys_q);
      default: bound = WordW'(ye_q);
    endcase
  end

  // Advance the sequencer on a tick, or restart it on a start
  always_comb begin
    phase_d = phase_q;
    pidx_d  = pidx_q;
    low_d   = low_q;
    left_d  = left_q;
    emit    = 1'b0;
    byte_d  = byte_q;
    data_d  = 1'b0;
    last_d  = 1'b0;
    if (accept && !start) begin
      emit = 1'b1;
      unique case (phase_q)
        PhCaset: begin
          byte_d  = CmdColAddrSet;
          phase_d = PhXParam;
          pidx_d  = '0;
        end
        PhXParam, PhYParam: begin
          byte_d = pidx_q[0] ? bound[7:0] : bound[15:8];
          data_d = 1'b1;
          if (pidx_q == 2'd3) begin
            phase_d = (phase_q == PhXParam) ? PhRaset : PhRamwr;
          end
          pidx_d = pidx_q + 2'd1;
        end
        PhRaset: begin
          byte_d  = CmdRowAddrSet;
          phase_d = PhYParam;
          pidx_d  = '0;
        end
        PhRamwr: begin
          byte_d = CmdMemWrite;
          if (left_q == '0) begin
            last_d  = 1'b1;
            phase_d = PhIdle;
          end else begin
            phase_d = PhPixels;
            low_d   = 1'b0;
          end
        end
        PhPixels: begin
          data_d = 1'b1;
          if (!low_q) begin
            byte_d = color_q[15:8];
            low_d  = 1'b1;
          end else begin
            byte_d = color_q[7:0];
            low_d  = 1'b0;
            left_d = left_q - CountW'(1);
            if (left_q == CountW'(1)) begin
              last_d  = 1'b1;
              phase_d = PhIdle;
            end
          end
        end
        default: begin
          emit    = 1'b0;
          phase_d = PhIdle;
        end
      endcase
    end else if (start) begin
      phase_d = PhCaset;
      pidx_d  = '0;
      low_d   = 1'b0;
      left_d  = CountW'(req_i.rect_width) * CountW'(req_i.rect_height);
    end
  end

  // Hold the output until taken, load a fresh byte when one is emitted
  always_comb begin
    if (accept) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q && !strm_o.ready;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      pidx_q      <= '0;
      low_q       <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pidx_q      <= pidx_d;
      low_q       <= low_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the window and colour on start
  always_ff @(posedge clk_i) begin
    if (start) begin
      xs_q    <= req_i.rect_x[COORD_BITS-1:0];
      xe_q    <= x_end_w[COORD_BITS-1:0];
      ys_q    <= req_i.rect_y[COORD_BITS-1:0];
      ye_q    <= y_end_w[COORD_BITS-1:0];
      color_q <= rgb565(req_i.red, req_i.green, req_i.blue);
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign strm_o.valid        = out_valid_q;
  assign strm_o.out_byte     = byte_q;
  assign strm_o.is_data      = data_q;
  assign strm_o.last_of_rect = last_q;

endmodule
